// ----- sv/gnd_pkg.sv -----
// Shared types and constants for the GNSS NMEA/UBX deframer.
`timescale 1ns / 1ps
package gnd_pkg;
  localparam int NmeaMaxLen = 96;
  localparam int UbxMaxFrame = 512;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN1    = 4'd4,
    PH_LEN2    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CKA     = 4'd7,
    PH_CKB     = 4'd8
  } phase_t;

  typedef enum logic [3:0] {
    EV_NMEA_OK   = 4'd0,
    EV_NO_CK     = 4'd1,
    EV_BAD_HEX   = 4'd2,
    EV_NMEA_MIS  = 4'd3,
    EV_TOO_LONG  = 4'd4,
    EV_UBX_OTHER = 4'd5,
    EV_NAV_PVT   = 4'd6,
    EV_NAV_STAT  = 4'd7,
    EV_UBX_MIS   = 4'd8,
    EV_PAY_LONG  = 4'd9
  } event_t;

  localparam logic [1:0] TYPE_NONE = 2'd0;
  localparam logic [1:0] TYPE_GGA  = 2'd1;
  localparam logic [1:0] TYPE_RMC  = 2'd2;
  localparam logic [1:0] TYPE_GSV  = 2'd3;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [7:0]  frame_class;
    logic [7:0]  msg_id;
    logic [8:0]  payload_len;
    logic [1:0]  sentence_type;
    logic        fix_valid;
    logic [7:0]  satellites;
    logic [31:0] longitude;
    logic [31:0] latitude;
    logic [31:0] altitude_mm;
    logic [15:0] dop;
  } result_t;

  // hex digit value, bit 4 set when not a hex character
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction
endpackage

// ----- sv/gnss_nmea_ubx_deframer_core.sv -----
// Top level: framer core and output register.
//   channel | signals                        | direction
//   in      | in_valid, in_stall, rx_byte    | into block
//   out     | out_valid, out_stall, fields   | out of block
// One byte is taken per cycle while in_stall is low; a result appears in the cycle after its byte.
// The output register holds a result while out_stall is high; in_stall is
// high exactly while a held result waits under out_stall.
// Synchronous reset clears all framer state and the output valid flag.
`timescale 1ns / 1ps
module gnss_nmea_ubx_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  event_res,
  output logic [7:0]  frame_class,
  output logic [7:0]  msg_id,
  output logic [8:0]  payload_len,
  output logic [1:0]  sentence_type,
  output logic        fix_valid,
  output logic [7:0]  satellites,
  output logic signed [31:0] longitude,
  output logic signed [31:0] latitude,
  output logic signed [31:0] altitude_mm,
  output logic [15:0] dop
);
  logic en, res_valid;
  gnd_pkg::result_t res, held;

  // stall input only when the output slot is full and blocked
  assign in_stall = out_valid && out_stall;
  assign en = in_valid && !in_stall;

  gnd_core u_core (
    .clk(clk), .rst(rst), .en(en), .b(rx_byte),
    .res_valid(res_valid), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= en && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && en && res_valid) held <= res;
  end

  assign event_res = held.event_res;
  assign frame_class = held.frame_class;
  assign msg_id = held.msg_id;
  assign payload_len = held.payload_len;
  assign sentence_type = held.sentence_type;
  assign fix_valid = held.fix_valid;
  assign satellites = held.satellites;
  assign longitude = held.longitude;
  assign latitude = held.latitude;
  assign altitude_mm = held.altitude_mm;
  assign dop = held.dop;
endmodule

// ----- sv/gnd_core.sv -----
// Per-byte framer state and result decision for NMEA and UBX.
`timescale 1ns / 1ps
module gnd_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [7:0]            b,
  output logic                  res_valid,
  output gnd_pkg::result_t      res
);
  gnd_pkg::phase_t ph, ph_next;
  logic nmea_active, nmea_active_next;
  logic [6:0] nmea_count, nmea_count_next;
  logic [7:0] nmea_xor, nmea_xor_next;
  logic star_seen, star_seen_next;
  logic [1:0] after_star_count, after_star_count_next;
  logic [15:0] hex_chars, hex_chars_next;
  logic [23:0] type_tail, type_tail_next;
  logic [1:0] type_len, type_len_next;
  logic type_done, type_done_next;
  logic [7:0] cur_class, cur_class_next, cur_id, cur_id_next;
  logic [15:0] cur_length, cur_length_next;
  logic [8:0] payload_count, payload_count_next;
  logic [7:0] sum_a, sum_a_next, sum_b, sum_b_next, rx_ck_a, rx_ck_a_next;
  logic [7:0] cap_fix, cap_fix_next, cap_flags, cap_flags_next, cap_sats, cap_sats_next;
  logic [31:0] cap_lon, cap_lon_next, cap_lat, cap_lat_next, cap_alt, cap_alt_next;
  logic [15:0] cap_dop, cap_dop_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= gnd_pkg::PH_IDLE;
      nmea_active <= 1'b0; nmea_count <= '0; nmea_xor <= '0; star_seen <= 1'b0;
      after_star_count <= '0; hex_chars <= '0; type_tail <= '0; type_len <= '0;
      type_done <= 1'b0; cur_class <= '0; cur_id <= '0; cur_length <= '0;
      payload_count <= '0; sum_a <= '0; sum_b <= '0; rx_ck_a <= '0;
      cap_fix <= '0; cap_flags <= '0; cap_sats <= '0; cap_lon <= '0;
      cap_lat <= '0; cap_alt <= '0; cap_dop <= '0;
    end else if (en) begin
      ph <= ph_next;
      nmea_active <= nmea_active_next; nmea_count <= nmea_count_next;
      nmea_xor <= nmea_xor_next; star_seen <= star_seen_next;
      after_star_count <= after_star_count_next; hex_chars <= hex_chars_next;
      type_tail <= type_tail_next; type_len <= type_len_next; type_done <= type_done_next;
      cur_class <= cur_class_next; cur_id <= cur_id_next; cur_length <= cur_length_next;
      payload_count <= payload_count_next; sum_a <= sum_a_next; sum_b <= sum_b_next;
      rx_ck_a <= rx_ck_a_next; cap_fix <= cap_fix_next; cap_flags <= cap_flags_next;
      cap_sats <= cap_sats_next; cap_lon <= cap_lon_next; cap_lat <= cap_lat_next;
      cap_alt <= cap_alt_next; cap_dop <= cap_dop_next;
    end
  end

  logic [7:0] sa, sb;
  logic [4:0] hhi, hlo;
  logic [8:0] off;
  logic [1:0] typ;
  logic valid;
  assign sa = sum_a + b;
  assign sb = sum_b + sa;
  assign hhi = gnd_pkg::hex_of(hex_chars[15:8]);
  assign hlo = gnd_pkg::hex_of(hex_chars[7:0]);
  assign off = payload_count;
  assign valid = (cap_fix >= 8'd2) && cap_flags[0];

  always_comb begin
    typ = gnd_pkg::TYPE_NONE;
    if (type_len == 2'd3) begin
      if (type_tail == 24'h474741) typ = gnd_pkg::TYPE_GGA;
      else if (type_tail == 24'h524D43) typ = gnd_pkg::TYPE_RMC;
      else if (type_tail == 24'h475356) typ = gnd_pkg::TYPE_GSV;
    end
  end

  always_comb begin
    ph_next = ph;
    nmea_active_next = nmea_active; nmea_count_next = nmea_count;
    nmea_xor_next = nmea_xor; star_seen_next = star_seen;
    after_star_count_next = after_star_count; hex_chars_next = hex_chars;
    type_tail_next = type_tail; type_len_next = type_len; type_done_next = type_done;
    cur_class_next = cur_class; cur_id_next = cur_id; cur_length_next = cur_length;
    payload_count_next = payload_count; sum_a_next = sum_a; sum_b_next = sum_b;
    rx_ck_a_next = rx_ck_a; cap_fix_next = cap_fix; cap_flags_next = cap_flags;
    cap_sats_next = cap_sats; cap_lon_next = cap_lon; cap_lat_next = cap_lat;
    cap_alt_next = cap_alt; cap_dop_next = cap_dop;
    res_valid = 1'b0;
    res = '0;
    if (b == 8'hB5 && !nmea_active &&
        (ph == gnd_pkg::PH_IDLE || ph == gnd_pkg::PH_SYNC2 || ph > gnd_pkg::PH_CKB)) begin
      ph_next = gnd_pkg::PH_SYNC2;
      sum_a_next = '0; sum_b_next = '0; cur_length_next = '0; payload_count_next = '0;
      cap_fix_next = '0; cap_flags_next = '0; cap_sats_next = '0; cap_lon_next = '0;
      cap_lat_next = '0; cap_alt_next = '0; cap_dop_next = '0;
    end else if (ph != gnd_pkg::PH_IDLE && ph <= gnd_pkg::PH_CKB) begin
      case (ph)
        gnd_pkg::PH_SYNC2: begin
          ph_next = (b == 8'h62) ? gnd_pkg::PH_CLASS : gnd_pkg::PH_IDLE;
        end
        gnd_pkg::PH_CLASS: begin
          cur_class_next = b; sum_a_next = sa; sum_b_next = sb; ph_next = gnd_pkg::PH_ID;
        end
        gnd_pkg::PH_ID: begin
          cur_id_next = b; sum_a_next = sa; sum_b_next = sb; ph_next = gnd_pkg::PH_LEN1;
        end
        gnd_pkg::PH_LEN1: begin
          cur_length_next = {8'd0, b}; sum_a_next = sa; sum_b_next = sb;
          ph_next = gnd_pkg::PH_LEN2;
        end
        gnd_pkg::PH_LEN2: begin
          cur_length_next = {b, cur_length[7:0]};
          sum_a_next = sa; sum_b_next = sb; payload_count_next = '0;
          if ({b, cur_length[7:0]} > 16'(gnd_pkg::UbxMaxFrame - 8)) begin
            ph_next = gnd_pkg::PH_IDLE;
            res_valid = 1'b1;
            res.event_res = gnd_pkg::EV_PAY_LONG;
            res.frame_class = cur_class;
            res.msg_id = cur_id;
          end else if ({b, cur_length[7:0]} == 16'd0) begin
            ph_next = gnd_pkg::PH_CKA;
          end else begin
            ph_next = gnd_pkg::PH_PAYLOAD;
          end
        end
        gnd_pkg::PH_PAYLOAD: begin
          sum_a_next = sa; sum_b_next = sb;
          if (cur_class == 8'h01 && cur_id == 8'h07) begin
            case (off)
              9'd20: cap_fix_next = b;
              9'd21: cap_flags_next = b;
              9'd23: cap_sats_next = b;
              9'd24: cap_lon_next[7:0] = b;
              9'd25: cap_lon_next[15:8] = b;
              9'd26: cap_lon_next[23:16] = b;
              9'd27: cap_lon_next[31:24] = b;
              9'd28: cap_lat_next[7:0] = b;
              9'd29: cap_lat_next[15:8] = b;
              9'd30: cap_lat_next[23:16] = b;
              9'd31: cap_lat_next[31:24] = b;
              9'd36: cap_alt_next[7:0] = b;
              9'd37: cap_alt_next[15:8] = b;
              9'd38: cap_alt_next[23:16] = b;
              9'd39: cap_alt_next[31:24] = b;
              9'd76: cap_dop_next[7:0] = b;
              9'd77: cap_dop_next[15:8] = b;
              default: ;
            endcase
          end else if (cur_class == 8'h01 && cur_id == 8'h03) begin
            if (off == 9'd4) cap_fix_next = b;
            else if (off == 9'd5) cap_flags_next = b;
          end
          payload_count_next = payload_count + 9'd1;
          if ({7'd0, payload_count + 9'd1} >= cur_length) ph_next = gnd_pkg::PH_CKA;
        end
        gnd_pkg::PH_CKA: begin
          rx_ck_a_next = b; ph_next = gnd_pkg::PH_CKB;
        end
        gnd_pkg::PH_CKB: begin
          ph_next = gnd_pkg::PH_IDLE;
          res_valid = 1'b1;
          res.frame_class = cur_class;
          res.msg_id = cur_id;
          res.payload_len = cur_length[8:0];
          if (sum_a != rx_ck_a || sum_b != b) begin
            res.event_res = gnd_pkg::EV_UBX_MIS;
          end else if (cur_class == 8'h01 && cur_id == 8'h07 && cur_length >= 16'd92) begin
            res.event_res = gnd_pkg::EV_NAV_PVT;
            res.fix_valid = valid; res.satellites = cap_sats;
            res.longitude = cap_lon; res.latitude = cap_lat;
            res.altitude_mm = cap_alt; res.dop = cap_dop;
          end else if (cur_class == 8'h01 && cur_id == 8'h03 && cur_length >= 16'd16) begin
            res.event_res = gnd_pkg::EV_NAV_STAT;
            res.fix_valid = valid;
          end else begin
            res.event_res = gnd_pkg::EV_UBX_OTHER;
          end
        end
        default: ph_next = gnd_pkg::PH_IDLE;
      endcase
    end else begin
      ph_next = gnd_pkg::PH_IDLE;
      if (b == 8'h24) begin
        nmea_active_next = 1'b1; nmea_count_next = 7'd1; nmea_xor_next = '0;
        star_seen_next = 1'b0; after_star_count_next = '0; hex_chars_next = '0;
        type_tail_next = '0; type_len_next = '0; type_done_next = 1'b0;
      end else if (nmea_active && b != 8'h0D) begin
        if (b == 8'h0A) begin
          nmea_active_next = 1'b0;
          res_valid = 1'b1;
          if (!star_seen || after_star_count < 2'd2) res.event_res = gnd_pkg::EV_NO_CK;
          else if (hhi[4] || hlo[4]) res.event_res = gnd_pkg::EV_BAD_HEX;
          else if ({hhi[3:0], hlo[3:0]} != nmea_xor) res.event_res = gnd_pkg::EV_NMEA_MIS;
          else begin
            res.event_res = gnd_pkg::EV_NMEA_OK;
            res.sentence_type = typ;
          end
        end else if (nmea_count >= 7'(gnd_pkg::NmeaMaxLen)) begin
          nmea_active_next = 1'b0;
          res_valid = 1'b1;
          res.event_res = gnd_pkg::EV_TOO_LONG;
        end else begin
          nmea_count_next = nmea_count + 7'd1;
          if (!star_seen) begin
            if (b == 8'h2A) begin
              star_seen_next = 1'b1; type_done_next = 1'b1;
            end else begin
              nmea_xor_next = nmea_xor ^ b;
              if (!type_done) begin
                if (b == 8'h2C) type_done_next = 1'b1;
                else begin
                  type_tail_next = {type_tail[15:0], b};
                  if (type_len < 2'd3) type_len_next = type_len + 2'd1;
                end
              end
            end
          end else if (after_star_count < 2'd2) begin
            hex_chars_next = {hex_chars[7:0], b};
            after_star_count_next = after_star_count + 2'd1;
          end
        end
      end
    end
  end
endmodule
